// ----- design/gpbg_pkg.sv -----
// Shared types, constants and helper functions for the Gaussian beam gain unit.
package gpbg_pkg;

    localparam int L_W       = 22;
    localparam int FREQ_W    = 32;
    localparam int FWHM_W    = 24;
    localparam int ANG_W     = 18;
    localparam int GAIN_W    = 17;
    localparam int R2_W      = 44;
    localparam int CS_W      = 36;
    localparam int DEN_W     = 56;
    localparam int V_W       = 63;
    localparam int DIV_STEPS = 88;
    localparam int NUM_SHIFT = 56;
    localparam int EXP_BITS  = 36;
    localparam int QDEPTH    = 8;
    localparam int QPTR_W    = 3;
    localparam int QCNT_W    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 24;
    localparam int ROUND_SHIFT = 46;

    localparam logic [V_W-1:0] CAP62 = 63'h4000_0000_0000_0000;
    localparam logic [V_W-1:0] EXP_K = 63'd2977044472;
    localparam logic [V_W-1:0] ROUND_HALF = 63'h0000_2000_0000_0000;

    typedef struct packed {
        logic [R2_W-1:0]   r2;
        logic [FREQ_W-1:0] freq;
    } item_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FWHM     = 3'd0,
        CFG_REF_FREQ = 3'd1,
        CFG_COS      = 3'd2,
        CFG_SIN      = 3'd3,
        CFG_SIN2     = 3'd4
    } cfg_index_t;

    function automatic logic [L_W-1:0] abs_coord(input logic [L_W-1:0] v);
        return v[L_W-1] ? (~v + {{(L_W-1){1'b0}}, 1'b1}) : v;
    endfunction

    function automatic logic [ANG_W-1:0] abs_angle(input logic [ANG_W-1:0] v);
        return v[ANG_W-1] ? (~v + {{(ANG_W-1){1'b0}}, 1'b1}) : v;
    endfunction

    // Factor exp(-2^(n-32)) in Q0.62, built by repeated truncated squaring.
    function automatic logic [V_W-1:0] exp_factor(input int unsigned n);
        logic [V_W-1:0]     f;
        logic [2*V_W-1:0]   p;
        f = CAP62 - (63'd1 << 30);
        for (int unsigned k = 0; k < n; k++) begin
            p = f * f;
            f = p[V_W+61:62];
        end
        return f;
    endfunction

endpackage

// ----- design/gaussian_primary_beam_gain_unit.sv -----
// Top level of the Gaussian primary beam gain unit with its configuration registers.
// A request passes the front stages, the queue, 89 divider stages, 40 four-stage
// multipliers and the output register before its result is valid.
// Throughput: one request per cycle; the whole back pipeline stalls only while the
// output register holds a result that is not taken.
// Reset: asynchronous active low; clears all valid flags, the queue and the registers
// to their documented defaults. Configuration takes effect through the derived registers.
module gaussian_primary_beam_gain_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gpbg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gpbg_pkg::CFG_DAT_W-1:0]     cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // l_coord [21:0], m_coord [43:22], freq_hz [75:44], zero fill above.
    input  logic [gpbg_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // gain [16:0], zero fill above.
    output logic [gpbg_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import gpbg_pkg::*;

    logic [FWHM_W-1:0]   fwhm_reg;
    logic [FREQ_W-1:0]   ref_freq_reg;
    logic [ANG_W-1:0]    cos_reg, sin_reg;
    logic [ANG_W-1:0]    cos_abs_reg, sin_abs_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [CS_W-1:0]     cs_reg;
    logic                zero_reg;

    logic                push, pop, q_empty;
    item_t               push_item, q_head;
    logic [QCNT_W-1:0]   q_count;
    logic [GAIN_W-1:0]   gain;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwhm_reg     <= '0;
            ref_freq_reg <= 32'd1;
            cos_reg      <= 18'h10000;
            sin_reg      <= '0;
            cos_abs_reg  <= 18'h10000;
            sin_abs_reg  <= '0;
            den_reg      <= '0;
            cs_reg       <= 36'h1_0000_0000;
            zero_reg     <= 1'b1;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_FWHM:     fwhm_reg     <= cfg_data[FWHM_W-1:0];
                    CFG_REF_FREQ: ref_freq_reg <= cfg_data;
                    CFG_COS:      cos_reg      <= cfg_data[ANG_W-1:0];
                    CFG_SIN:      sin_reg      <= cfg_data[ANG_W-1:0];
                    // Both axes share one sigma, so the cross term vanishes.
                    CFG_SIN2:     ;
                    default:      ;
                endcase
            end
            cos_abs_reg <= abs_angle(cos_reg);
            sin_abs_reg <= abs_angle(sin_reg);
            den_reg     <= fwhm_reg * ref_freq_reg;
            cs_reg      <= cos_abs_reg * cos_abs_reg + sin_abs_reg * sin_abs_reg;
            zero_reg    <= (fwhm_reg == '0) || (ref_freq_reg == '0);
        end
    end

    gpbg_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_l      (s_axis_tdata[L_W-1:0]),
        .in_m      (s_axis_tdata[2*L_W-1:L_W]),
        .in_freq   (s_axis_tdata[2*L_W+FREQ_W-1:2*L_W]),
        .q_count   (q_count),
        .push      (push),
        .push_item (push_item)
    );

    gpbg_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (q_head),
        .empty     (q_empty),
        .count     (q_count)
    );

    gpbg_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .pop       (pop),
        .den       (den_reg),
        .cs        (cs_reg),
        .zero_gain (zero_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_gain  (gain)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-GAIN_W){1'b0}}, gain};

    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (q_count < QCNT_W'(QDEPTH)))
        else $error("queue written while full");

    a_zero_width: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && zero_reg) |-> (gain == '0))
        else $error("nonzero gain with zero beam width");

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (gain <= 17'h10000))
        else $error("gain above unity");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (q_empty && !push) |=> (q_count == '0))
        else $error("queue count changed without a push");

endmodule

// ----- design/gpbg_front.sv -----
// Front end: accepts requests, forms the squared radius and feeds the queue.
module gpbg_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [gpbg_pkg::L_W-1:0]      in_l,
    input  logic [gpbg_pkg::L_W-1:0]      in_m,
    input  logic [gpbg_pkg::FREQ_W-1:0]   in_freq,
    input  logic [gpbg_pkg::QCNT_W-1:0]   q_count,
    output logic                          push,
    output gpbg_pkg::item_t               push_item
);
    import gpbg_pkg::*;

    logic                 s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [L_W-1:0]       la_reg, ma_reg;
    logic [R2_W-1:0]      lsq_reg, msq_reg;
    logic [FREQ_W-1:0]    freq1_reg, freq2_reg;
    item_t                item_reg;
    logic [QCNT_W-1:0]    occupancy;
    logic                 accept;

    assign occupancy = q_count + QCNT_W'(s1_valid_reg) + QCNT_W'(s2_valid_reg)
                     + QCNT_W'(s3_valid_reg);
    assign in_ready  = occupancy < QCNT_W'(QDEPTH);
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        la_reg        <= abs_coord(in_l);
        ma_reg        <= abs_coord(in_m);
        freq1_reg     <= in_freq;
        lsq_reg       <= la_reg * la_reg;
        msq_reg       <= ma_reg * ma_reg;
        freq2_reg     <= freq1_reg;
        item_reg.r2   <= lsq_reg + msq_reg;
        item_reg.freq <= freq2_reg;
    end

    assign push      = s3_valid_reg;
    assign push_item = item_reg;

endmodule

// ----- design/gpbg_queue.sv -----
// Short queue that decouples the front end from the arithmetic pipeline.
module gpbg_queue
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  gpbg_pkg::item_t              push_item,
    input  logic                         pop,
    output gpbg_pkg::item_t              head,
    output logic                         empty,
    output logic [gpbg_pkg::QCNT_W-1:0]  count
);
    import gpbg_pkg::*;

    item_t              mem_reg [0:QDEPTH-1];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               do_pop;

    assign empty  = count_reg == '0;
    assign do_pop = pop && !empty;
    assign head   = mem_reg[rd_ptr_reg];
    assign count  = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(do_pop);
        end
    end

endmodule

// ----- design/gpbg_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, saturating at 2^62.
module gpbg_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic [gpbg_pkg::FREQ_W-1:0]   num,
    input  logic [gpbg_pkg::DEN_W-1:0]    den,
    input  logic [gpbg_pkg::R2_W:0]       side_in,
    output logic [gpbg_pkg::V_W-1:0]      quot,
    output logic [gpbg_pkg::R2_W:0]       side_out
);
    import gpbg_pkg::*;

    logic [DEN_W-1:0]   rem_reg  [0:DIV_STEPS];
    logic [V_W-1:0]     q_reg    [0:DIV_STEPS];
    logic               sat_reg  [0:DIV_STEPS];
    logic [FREQ_W-1:0]  num_reg  [0:DIV_STEPS];
    logic [R2_W:0]      side_reg [0:DIV_STEPS];
    logic [V_W-1:0]     q_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg[0] <= '0;
        end
        else if (en)
        begin
            side_reg[0] <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= '0;
            q_reg[0]   <= '0;
            sat_reg[0] <= 1'b0;
            num_reg[0] <= num;
        end
    end

    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_step
        localparam int BitPos = DIV_STEPS - 1 - s;
        logic             in_bit;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             take;

        if (BitPos >= NUM_SHIFT)
        begin : g_num
            assign in_bit = num_reg[s][BitPos-NUM_SHIFT];
        end
        else
        begin : g_zero
            assign in_bit = 1'b0;
        end

        assign trial = {rem_reg[s], in_bit};
        assign diff  = trial - {1'b0, den};
        assign take  = trial >= {1'b0, den};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                side_reg[s+1] <= '0;
            end
            else if (en)
            begin
                side_reg[s+1] <= side_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                q_reg[s+1]   <= {q_reg[s][V_W-2:0], take};
                sat_reg[s+1] <= sat_reg[s] | q_reg[s][V_W-1];
                num_reg[s+1] <= num_reg[s];
            end
        end
    end

    assign q_last   = q_reg[DIV_STEPS];
    assign quot     = (sat_reg[DIV_STEPS] || (q_last[V_W-1] && |q_last[V_W-2:0]))
                    ? CAP62 : q_last;
    assign side_out = side_reg[DIV_STEPS];

endmodule

// ----- design/gpbg_mul.sv -----
// Four-stage 63 x 63 multiplier from 32-bit partial products, shifted and saturated.
module gpbg_mul
#(
    parameter int SHIFT  = 32,
    parameter int SIDE_W = 1
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic [gpbg_pkg::V_W-1:0]  a,
    input  logic [gpbg_pkg::V_W-1:0]  b,
    input  logic [SIDE_W-1:0]         side_in,
    output logic [gpbg_pkg::V_W-1:0]  prod,
    output logic [SIDE_W-1:0]         side_out
);
    import gpbg_pkg::*;

    localparam int FULL_W = 128;

    logic [63:0]         p00_reg, p01_reg, p10_reg, p11_reg;
    logic [63:0]         q00_reg, q11_reg;
    logic [64:0]         mid_reg;
    logic [FULL_W-1:0]   full_reg;
    logic [V_W-1:0]      prod_reg;
    logic [SIDE_W-1:0]   side1_reg, side2_reg, side3_reg, side4_reg;
    logic [FULL_W-1:0]   shifted;
    logic [V_W-1:0]      clipped;

    assign shifted = full_reg >> SHIFT;
    assign clipped = (|shifted[FULL_W-1:V_W] || (shifted[V_W-1] && |shifted[V_W-2:0]))
                   ? CAP62 : shifted[V_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg  <= a[31:0] * b[31:0];
            p01_reg  <= 64'(a[31:0] * b[V_W-1:32]);
            p10_reg  <= 64'(a[V_W-1:32] * b[31:0]);
            p11_reg  <= 64'(a[V_W-1:32] * b[V_W-1:32]);
            mid_reg  <= {1'b0, p01_reg} + {1'b0, p10_reg};
            q00_reg  <= p00_reg;
            q11_reg  <= p11_reg;
            full_reg <= {q11_reg, q00_reg} + {31'b0, mid_reg, 32'b0};
            prod_reg <= clipped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side1_reg <= '0;
            side2_reg <= '0;
            side3_reg <= '0;
            side4_reg <= '0;
        end
        else if (en)
        begin
            side1_reg <= side_in;
            side2_reg <= side1_reg;
            side3_reg <= side2_reg;
            side4_reg <= side3_reg;
        end
    end

    assign prod     = prod_reg;
    assign side_out = side4_reg;

endmodule

// ----- design/gpbg_back.sv -----
// Back end: division, multiply chain, exponential and the output register.
module gpbg_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  gpbg_pkg::item_t               q_head,
    output logic                          pop,
    input  logic [gpbg_pkg::DEN_W-1:0]    den,
    input  logic [gpbg_pkg::CS_W-1:0]     cs,
    input  logic                          zero_gain,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [gpbg_pkg::GAIN_W-1:0]   out_gain
);
    import gpbg_pkg::*;

    localparam int EXP_SIDE_W = EXP_BITS + 2;

    logic                  adv;
    logic [V_W-1:0]        h, h2, t1, t2, x;
    logic [R2_W:0]         div_side, h2_side;
    logic                  t1_valid, t2_valid, x_valid;
    logic [V_W-1:0]        exp_res  [0:EXP_BITS];
    logic [EXP_SIDE_W-1:0] exp_side [0:EXP_BITS];
    logic [V_W-1:0]        rounded;
    logic                  out_valid_reg;
    logic [GAIN_W-1:0]     gain_reg;
    logic [GAIN_W-1:0]     gain_next;

    assign adv = !out_valid_reg || out_ready;
    assign pop = adv && !q_empty;

    gpbg_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .num      (q_head.freq),
        .den      (den),
        .side_in  ({q_head.r2, pop}),
        .quot     (h),
        .side_out (div_side)
    );

    gpbg_mul #(.SHIFT(32), .SIDE_W(R2_W + 1)) u_mul_h2
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .a        (h),
        .b        (h),
        .side_in  (div_side),
        .prod     (h2),
        .side_out (h2_side)
    );

    gpbg_mul #(.SHIFT(40), .SIDE_W(1)) u_mul_t1
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .a        (h2),
        .b        ({{(V_W-R2_W){1'b0}}, h2_side[R2_W:1]}),
        .side_in  (h2_side[0]),
        .prod     (t1),
        .side_out (t1_valid)
    );

    gpbg_mul #(.SHIFT(32), .SIDE_W(1)) u_mul_t2
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .a        (t1),
        .b        ({{(V_W-CS_W){1'b0}}, cs}),
        .side_in  (t1_valid),
        .prod     (t2),
        .side_out (t2_valid)
    );

    gpbg_mul #(.SHIFT(30), .SIDE_W(1)) u_mul_x
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .a        (t2),
        .b        (EXP_K),
        .side_in  (t2_valid),
        .prod     (x),
        .side_out (x_valid)
    );

    assign exp_res[0]  = CAP62;
    assign exp_side[0] = {|x[V_W-1:EXP_BITS], x[EXP_BITS-1:0], x_valid};

    for (genvar i = 0; i < EXP_BITS; i++)
    begin : g_exp
        localparam logic [V_W-1:0] Factor = exp_factor(i);

        gpbg_mul #(.SHIFT(62), .SIDE_W(EXP_SIDE_W)) u_mul_exp
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .a        (exp_res[i]),
            .b        (exp_side[i][i+1] ? Factor : CAP62),
            .side_in  (exp_side[i]),
            .prod     (exp_res[i+1]),
            .side_out (exp_side[i+1])
        );
    end

    assign rounded   = exp_res[EXP_BITS] + ROUND_HALF;
    assign gain_next = (exp_side[EXP_BITS][EXP_SIDE_W-1] || zero_gain)
                     ? '0 : rounded[ROUND_SHIFT+GAIN_W-1:ROUND_SHIFT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= exp_side[EXP_BITS][0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gain_reg <= gain_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_gain  = gain_reg;

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the Gaussian primary beam gain unit.
`timescale 1ns / 1ps

module tb_top;
    import gpbg_pkg::*;

    typedef struct {
        logic [21:0] l;
        logic [21:0] m;
        logic [31:0] freq;
        bit          known;
        logic [16:0] gain;
    } beam_row_t;

    typedef struct {
        logic [23:0] fwhm;
        logic [31:0] ref_hz;
        logic [17:0] cos_a;
        logic [17:0] sin_a;
        logic [17:0] sin2_a;
    } beam_cfg_t;

    localparam logic [63:0] SAT62 = 64'h4000_0000_0000_0000;
    localparam logic [63:0] LN_K  = 64'd2977044472;
    localparam int STALL_LIMIT = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    beam_cfg_t beam_cfg;
    logic [16:0] gain_queue[$];
    int mismatches = 0;
    int gains_seen = 0;
    int idle_cycles = 0;
    bit steady = 1'b0;

    always #10 clk = ~clk;

    gaussian_primary_beam_gain_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> sh;
        if (p > {64'd0, SAT62})
            return SAT62;
        return p[63:0];
    endfunction

    function automatic logic [63:0] magnitude(logic [63:0] v, int w);
        if (v[w-1])
            return (64'd1 << w) - v;
        return v;
    endfunction

    function automatic logic [16:0] beam_gain(logic [21:0] l, logic [21:0] m,
                                              logic [31:0] freq);
        logic [63:0] ca, sa, cs, la, ma, r2, h, h2, t1, t2, x, res, f;
        logic [127:0] q;
        if (beam_cfg.fwhm == 0 || beam_cfg.ref_hz == 0)
            return 17'd0;
        ca = magnitude({46'd0, beam_cfg.cos_a}, 18);
        sa = magnitude({46'd0, beam_cfg.sin_a}, 18);
        cs = ca * ca + sa * sa;
        la = magnitude({42'd0, l}, 22);
        ma = magnitude({42'd0, m}, 22);
        r2 = la * la + ma * ma;
        q = ({96'd0, freq} << 56) / ({104'd0, beam_cfg.fwhm} * {96'd0, beam_cfg.ref_hz});
        h = (q > {64'd0, SAT62}) ? SAT62 : q[63:0];
        h2 = mul_shift(h, h, 32);
        t1 = mul_shift(h2, r2, 40);
        t2 = mul_shift(t1, cs, 32);
        x = mul_shift(t2, LN_K, 30);
        if (x >= (64'd1 << 36))
            return 17'd0;
        res = SAT62;
        f = SAT62 - (64'd1 << 30);
        for (int i = 0; i < 36; i++)
        begin
            if (x[i])
                res = mul_shift(res, f, 62);
            f = mul_shift(f, f, 62);
        end
        res = (res + (64'd1 << 45)) >> 46;
        return res[16:0];
    endfunction

    task automatic write_reg(cfg_index_t idx, logic [31:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_beam(beam_cfg_t c);
        while (gain_queue.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        write_reg(CFG_FWHM, {8'd0, c.fwhm});
        write_reg(CFG_REF_FREQ, c.ref_hz);
        write_reg(CFG_COS, {{14{c.cos_a[17]}}, c.cos_a});
        write_reg(CFG_SIN, {14'($urandom_range(0, 16383)), c.sin_a});
        write_reg(CFG_SIN2, {{14{c.sin2_a[17]}}, c.sin2_a});
        beam_cfg = c;
    endtask

    task automatic send_item(beam_row_t row);
        while (!steady && $urandom_range(0, 99) < 9)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        gain_queue.push_back(row.known ? row.gain : beam_gain(row.l, row.m, row.freq));
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {4'd0, row.freq, row.m, row.l};
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    function automatic logic [17:0] pick_angle();
        case ($urandom_range(0, 3))
            0: return 18'sd65536;
            1: return -18'sd65536;
            2: return 18'd0;
            default: return 18'($signed($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    function automatic logic [21:0] pick_coord(logic [23:0] fw);
        int unsigned span;
        span = (fw >> 3) + 2;
        if ($urandom_range(0, 9) == 0)
            return 22'($urandom);
        return 22'($signed($urandom_range(0, 2 * span)) - $signed(span));
    endfunction

    always @(negedge clk)
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 9);

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            gains_seen++;
            if (gain_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected gain %0d", m_axis_tdata[16:0]);
            end
            else
            begin
                logic [16:0] want;
                want = gain_queue.pop_front();
                if (m_axis_tdata[16:0] !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("gain mismatch: expected %0d actual %0d",
                                 want, m_axis_tdata[16:0]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        beam_row_t rows[$];
        beam_row_t r;
        beam_cfg_t c;
        beam_cfg = '{24'd0, 32'd1, 18'sd65536, 18'd0, 18'd0};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset width is zero, so every gain is zero.
        rows = '{
            '{22'h0, 22'h0, 32'd1, 1, 17'd0},
            '{22'h1fffff, 22'h200000, 32'hffffffff, 1, 17'd0}
        };
        foreach (rows[i])
            send_item(rows[i]);

        load_beam('{24'h100000, 32'd150000000, 18'sd65536, 18'd0, 18'd0});
        rows = '{
            '{22'h0, 22'h0, 32'd150000000, 1, 17'd65536},
            '{22'h12345, 22'h3eedcb, 32'd0, 1, 17'd65536},
            '{22'h1fffff, 22'h1fffff, 32'hffffffff, 1, 17'd0},
            '{22'h200000, 22'h200000, 32'hffffffff, 1, 17'd0},
            '{22'h8000, 22'h0, 32'd150000000, 0, 17'd0},
            '{22'h0, 22'h3f8000, 32'd150000000, 0, 17'd0},
            '{22'h10000, 22'h10000, 32'd75000000, 0, 17'd0},
            '{22'h4000, 22'h3fc000, 32'd1, 0, 17'd0},
            '{22'h200000, 22'h0, 32'd1, 0, 17'd0}
        };
        foreach (rows[i])
            send_item(rows[i]);

        load_beam('{24'hffffff, 32'hffffffff, -18'sd65536, 18'sd65536, -18'sd65536});
        rows = '{
            '{22'h0, 22'h0, 32'hffffffff, 1, 17'd65536},
            '{22'h100000, 22'h100000, 32'hffffffff, 0, 17'd0},
            '{22'h1fffff, 22'h200000, 32'h7fffffff, 0, 17'd0}
        };
        foreach (rows[i])
            send_item(rows[i]);

        load_beam('{24'h000001, 32'd0, 18'd0, 18'd0, 18'sd65536});
        rows = '{
            '{22'h0, 22'h0, 32'd1, 1, 17'd0},
            '{22'h5, 22'h3, 32'd0, 1, 17'd0}
        };
        foreach (rows[i])
            send_item(rows[i]);

        for (int p = 0; p < 6; p++)
        begin
            int k;
            k = $urandom_range(1, 24);
            c.fwhm = (p == 0) ? 24'hffffff
                   : (24'($urandom) & ((24'd1 << k) - 1)) | (24'd1 << (k - 1));
            k = $urandom_range(1, 32);
            c.ref_hz = (p == 1) ? 32'd1 : (p == 0) ? 32'hffffffff
                     : ($urandom & (32'hffffffff >> (32 - k))) | (32'd1 << (k - 1));
            c.cos_a = pick_angle();
            c.sin_a = pick_angle();
            c.sin2_a = pick_angle();
            load_beam(c);
            steady = (p == 3);
            for (int n = 0; n < 255; n++)
            begin
                r.l = pick_coord(c.fwhm);
                r.m = pick_coord(c.fwhm);
                if ($urandom_range(0, 9) < 7)
                    r.freq = 32'((64'(c.ref_hz) * $urandom_range(40, 250)) / 100);
                else
                    r.freq = $urandom;
                r.known = 1'b0;
                send_item(r);
            end
            steady = 1'b0;
        end

        while (gain_queue.size() != 0)
            @(negedge clk);
        repeat (300) @(posedge clk);
        $display("Checked %0d gains over ten beam settings, including zero width,",
                 gains_seen);
        $display("zero reference, extreme angles and coordinate and frequency extremes.");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// ----- files.f -----
design/gpbg_pkg.sv
design/gpbg_front.sv
design/gpbg_queue.sv
design/gpbg_div.sv
design/gpbg_mul.sv
design/gpbg_back.sv
design/gaussian_primary_beam_gain_unit.sv
bench/tb_top.sv
